FILE: sv/brd_pkg.sv
package brd_pkg;

    // Map geometry
    localparam int MAP_ENTRIES = 65536;
    localparam int ADDR_W      = $clog2(MAP_ENTRIES);

    // Operation codes
    localparam logic [1:0] OP_INT  = 2'd0;
    localparam logic [1:0] OP_STR  = 2'd1;
    localparam logic [1:0] OP_BSTR = 2'd2;

    // Direction codes held in the two low bits of an entry
    localparam logic [1:0] DIR_NONE      = 2'd0;
    localparam logic [1:0] DIR_TAKEN     = 2'd1;
    localparam logic [1:0] DIR_NOT_TAKEN = 2'd2;
    localparam logic [1:0] DIR_BOTH      = 2'd3;

    // Operand size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    // One item waiting on its map read
    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         predicate;
        logic [1:0]         operand_size;
        logic signed [63:0] left_operand;
        logic signed [63:0] right_operand;
        logic signed [31:0] compare_result;
        logic [5:0]         compare_length;
    } t_item;

    // Result of the entry update
    typedef struct packed {
        logic [7:0] value;
        logic       wr;
    } t_upd;

    // New direction for current direction d and outcome o, DIR_NONE if no write
    function automatic logic [1:0] next_dir(input logic [1:0] d, input logic [1:0] o);
        logic [1:0] r;
        r = DIR_NONE;
        if (d == DIR_NONE)
            r = o;
        else if (d == DIR_NOT_TAKEN && o == DIR_TAKEN)
            r = DIR_BOTH;
        else if (d == DIR_TAKEN && o == DIR_NOT_TAKEN)
            r = DIR_BOTH;
        return r;
    endfunction

endpackage

FILE: sv/brd_ram.sv
module brd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port, registered read port (old data on same-cycle collision)
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re)
            o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: sv/brd_update.sv
module brd_update (
    input  brd_pkg::t_item i_item,
    input  logic [7:0]     i_cur,
    output brd_pkg::t_upd  o_upd
);
    import brd_pkg::*;

    logic signed [63:0] w_a;
    logic signed [63:0] w_b;
    logic [1:0]         w_outcome;
    logic [1:0]         w_nd;

    function automatic logic signed [63:0] sext(input logic [63:0] v, input logic [1:0] sz);
        logic signed [63:0] r;
        case (sz)
            SIZE_8:  r = {{56{v[7]}}, v[7:0]};
            SIZE_16: r = {{48{v[15]}}, v[15:0]};
            SIZE_32: r = {{32{v[31]}}, v[31:0]};
            SIZE_64: r = v;
            default: r = v;
        endcase
        return r;
    endfunction

    assign w_a = sext(i_item.left_operand, i_item.operand_size);
    assign w_b = sext(i_item.right_operand, i_item.operand_size);

    // Branch outcome
    always_comb begin
        w_outcome = DIR_NONE;
        if (i_item.operation == OP_INT) begin
            case (i_item.predicate) inside
                4'd0, 4'd1:        w_outcome = (w_a >  w_b) ? DIR_TAKEN : DIR_NOT_TAKEN;
                4'd2, 4'd7, 4'd11: w_outcome = (w_a == w_b) ? DIR_TAKEN : DIR_NOT_TAKEN;
                4'd3, 4'd4:        w_outcome = (w_a >= w_b) ? DIR_TAKEN : DIR_NOT_TAKEN;
                4'd5, 4'd6:        w_outcome = (w_a <  w_b) ? DIR_TAKEN : DIR_NOT_TAKEN;
                4'd8, 4'd9:        w_outcome = (w_a <= w_b) ? DIR_TAKEN : DIR_NOT_TAKEN;
                default:           w_outcome = DIR_NONE;
            endcase
        end else if (i_item.operation == OP_STR || i_item.operation == OP_BSTR) begin
            w_outcome = (i_item.compare_result == 32'sd0) ? DIR_TAKEN : DIR_NOT_TAKEN;
        end
    end

    assign w_nd = next_dir(i_cur[1:0], w_outcome);

    // Entry transition; full-byte modes skip bytes carrying length bits
    always_comb begin
        o_upd.wr    = 1'b0;
        o_upd.value = i_cur;
        if (w_outcome != DIR_NONE && w_nd != DIR_NONE) begin
            if (i_item.operation == OP_BSTR) begin
                o_upd.wr    = 1'b1;
                o_upd.value = {i_item.compare_length, w_nd};
            end else if (i_cur[7:2] == 6'd0) begin
                o_upd.wr    = 1'b1;
                o_upd.value = {6'd0, w_nd};
            end
        end
    end

endmodule

FILE: sv/branch_direction_recorder.sv
// An accepted item passes the read stage (registered map read) and then the
// output register; a stalled output holds both. Throughput: one item per cycle
// while the output is not stalled; the map read-modify-write forwards a write
// issued in the same cycle as the next read, so same-entry items follow freely.
// Reset: synchronous, active low. After reset the map is cleared one entry per
// cycle, all MAP_ENTRIES (65536) entries, with o_stall high throughout.
module branch_direction_recorder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_branch_id,
    input  logic [3:0]  i_predicate,
    input  logic [1:0]  i_operand_size,
    input  logic signed [63:0] i_left_operand,
    input  logic signed [63:0] i_right_operand,
    input  logic signed [31:0] i_compare_result,
    input  logic [5:0]  i_compare_length,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_entry_value,
    output logic        o_entry_updated
);
    import brd_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic                r_rd_valid;
    t_item               r_rd_item;
    logic [ADDR_W-1:0]   r_rd_addr;
    logic                r_fwd_hit;
    logic [7:0]          r_fwd_data;
    logic                r_out_valid;
    logic [7:0]          r_out_value;
    logic                r_out_upd;

    logic                w_clearing;
    logic                w_out_free;
    logic                w_rd_adv;
    logic                w_accept;
    logic [ADDR_W-1:0]   w_in_addr;
    logic                w_ram_we;
    logic [ADDR_W-1:0]   w_ram_waddr;
    logic [7:0]          w_ram_wdata;
    logic [7:0]          w_ram_rdata;
    logic [7:0]          w_cur;
    t_upd                w_upd;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr_addr == ADDR_W'(MAP_ENTRIES - 1)) n_state = ST_RUN;
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb begin
        case (r_state)
            ST_CLEAR: w_clearing = 1'b1;
            ST_RUN:   w_clearing = 1'b0;
            default:  w_clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing)
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Handshake
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_rd_adv   = r_rd_valid && w_out_free;
    assign o_stall    = w_clearing || (r_rd_valid && !w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign w_in_addr  = ADDR_W'(32'(i_branch_id) % MAP_ENTRIES);

    // Map write port: clearing pass or update
    always_comb begin
        if (w_clearing) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = 8'd0;
        end else begin
            w_ram_we    = w_rd_adv && w_upd.wr;
            w_ram_waddr = r_rd_addr;
            w_ram_wdata = w_upd.value;
        end
    end

    brd_ram #(
        .WIDTH (8),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_addr),
        .o_rdata (w_ram_rdata)
    );

    // Read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_rd_valid <= 1'b0;
        else if (w_accept)
            r_rd_valid <= 1'b1;
        else if (w_rd_adv)
            r_rd_valid <= 1'b0;
    end

    // Read stage payload and forward capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_addr                <= w_in_addr;
            r_rd_item.operation      <= i_operation;
            r_rd_item.predicate      <= i_predicate;
            r_rd_item.operand_size   <= i_operand_size;
            r_rd_item.left_operand   <= i_left_operand;
            r_rd_item.right_operand  <= i_right_operand;
            r_rd_item.compare_result <= i_compare_result;
            r_rd_item.compare_length <= i_compare_length;
            r_fwd_hit                <= w_ram_we && (w_ram_waddr == w_in_addr);
            r_fwd_data               <= w_ram_wdata;
        end
    end

    assign w_cur = r_fwd_hit ? r_fwd_data : w_ram_rdata;

    brd_update u_update (
        .i_item (r_rd_item),
        .i_cur  (w_cur),
        .o_upd  (w_upd)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (w_rd_adv)
            r_out_valid <= 1'b1;
        else if (!i_stall)
            r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_adv) begin
            r_out_value <= w_upd.value;
            r_out_upd   <= w_upd.wr;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entry_value   = r_out_value;
    assign o_entry_updated = r_out_upd;

    // Checks
    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !r_rd_valid)
        else $error("item in read stage during map clear");

    a_rd_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !w_out_free) |=> $stable(w_ram_rdata))
        else $error("map read data lost while read stage stalled");

    a_out_from_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_rd_valid))
        else $error("result without a read-stage item");

    a_upd_has_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_upd) |-> (r_out_value[1:0] != DIR_NONE))
        else $error("written entry has no direction");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brd_pkg::*;

    // Predicate codes of the integer compare
    localparam logic [3:0] PRED_GT_A      = 4'd0;
    localparam logic [3:0] PRED_GT_B      = 4'd1;
    localparam logic [3:0] PRED_EQ_A      = 4'd2;
    localparam logic [3:0] PRED_GE_A      = 4'd3;
    localparam logic [3:0] PRED_GE_B      = 4'd4;
    localparam logic [3:0] PRED_LT_A      = 4'd5;
    localparam logic [3:0] PRED_LT_B      = 4'd6;
    localparam logic [3:0] PRED_EQ_B      = 4'd7;
    localparam logic [3:0] PRED_LE_A      = 4'd8;
    localparam logic [3:0] PRED_LE_B      = 4'd9;
    localparam logic [3:0] PRED_UNKNOWN_A = 4'd10;
    localparam logic [3:0] PRED_EQ_C      = 4'd11;
    localparam logic [3:0] PRED_UNKNOWN_Z = 4'd15;

    // Operation code with no meaning
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        branch_id;
        logic [3:0]         predicate;
        logic [1:0]         operand_size;
        logic signed [63:0] left_operand;
        logic signed [63:0] right_operand;
        logic signed [31:0] compare_result;
        logic [5:0]         compare_length;
    } t_branch_item;

    typedef struct packed {
        logic [7:0] value;
        logic       updated;
    } t_entry_result;

    typedef struct packed {
        t_branch_item  item;
        logic          typed;
        t_entry_result want;
    } t_directed_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_operation = OP_INT;
    logic [15:0]        i_branch_id = '0;
    logic [3:0]         i_predicate = PRED_GT_A;
    logic [1:0]         i_operand_size = SIZE_8;
    logic signed [63:0] i_left_operand = '0;
    logic signed [63:0] i_right_operand = '0;
    logic signed [31:0] i_compare_result = '0;
    logic [5:0]         i_compare_length = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_entry_value;
    logic               o_entry_updated;

    // Predictor state and the results still owed by the block
    logic [7:0]    direction_map [MAP_ENTRIES];
    t_entry_result expected_entries [$];
    t_directed_row directed_rows [$];

    int          tx_idle_pct = 20;
    int          rx_stall_pct = 69;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [15:0] hot_base = '0;

    branch_direction_recorder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_branch_id      (i_branch_id),
        .i_predicate      (i_predicate),
        .i_operand_size   (i_operand_size),
        .i_left_operand   (i_left_operand),
        .i_right_operand  (i_right_operand),
        .i_compare_result (i_compare_result),
        .i_compare_length (i_compare_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_entry_value    (o_entry_value),
        .o_entry_updated  (o_entry_updated)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sign extend the low bits selected by the size code
    function automatic logic signed [63:0] widen(input logic signed [63:0] v,
                                                 input logic [1:0] size);
        logic signed [63:0] w;
        case (size)
            SIZE_8:  w = {{56{v[7]}}, v[7:0]};
            SIZE_16: w = {{48{v[15]}}, v[15:0]};
            SIZE_32: w = {{32{v[31]}}, v[31:0]};
            default: w = v;
        endcase
        return w;
    endfunction

    // Direction after an outcome, DIR_NONE when the entry stays as it is
    function automatic logic [1:0] advance_direction(input logic [1:0] now,
                                                     input logic [1:0] outcome);
        logic [1:0] nxt;
        nxt = DIR_NONE;
        if (now == DIR_NONE)
            nxt = outcome;
        else if (now != outcome && now != DIR_BOTH)
            nxt = DIR_BOTH;
        return nxt;
    endfunction

    // Apply one item to the map copy and return what the block must report
    function automatic t_entry_result record_branch(input t_branch_item it);
        logic [7:0]         cur;
        logic [1:0]         outcome;
        logic [1:0]         dir_next;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic               taken;
        t_entry_result      res;
        cur = direction_map[it.branch_id];
        outcome = DIR_NONE;
        res.updated = 1'b0;
        case (it.operation)
            OP_INT: begin
                a = widen(it.left_operand, it.operand_size);
                b = widen(it.right_operand, it.operand_size);
                taken = 1'b0;
                outcome = DIR_NOT_TAKEN;
                case (it.predicate)
                    PRED_GT_A, PRED_GT_B:            taken = (a > b);
                    PRED_EQ_A, PRED_EQ_B, PRED_EQ_C: taken = (a == b);
                    PRED_GE_A, PRED_GE_B:            taken = (a >= b);
                    PRED_LT_A, PRED_LT_B:            taken = (a < b);
                    PRED_LE_A, PRED_LE_B:            taken = (a <= b);
                    default:                         outcome = DIR_NONE;
                endcase
                if (outcome != DIR_NONE && taken)
                    outcome = DIR_TAKEN;
            end
            OP_STR, OP_BSTR: begin
                outcome = (it.compare_result == 0) ? DIR_TAKEN : DIR_NOT_TAKEN;
            end
            default: ;
        endcase
        if (outcome != DIR_NONE) begin
            if (it.operation == OP_BSTR) begin
                // only the direction bits count, length packed above them
                dir_next = advance_direction(cur[1:0], outcome);
                if (dir_next != DIR_NONE) begin
                    direction_map[it.branch_id] = {it.compare_length, dir_next};
                    res.updated = 1'b1;
                end
            end else if (cur <= {6'd0, DIR_BOTH}) begin
                // whole byte must be a plain direction
                dir_next = advance_direction(cur[1:0], outcome);
                if (dir_next != DIR_NONE) begin
                    direction_map[it.branch_id] = {6'd0, dir_next};
                    res.updated = 1'b1;
                end
            end
        end
        res.value = direction_map[it.branch_id];
        return res;
    endfunction

    // Random item; most ids fall in a small window so entries see several hits
    function automatic t_branch_item make_random_item(input logic [15:0] base);
        t_branch_item it;
        int           pick;
        pick = $urandom_range(19);
        if (pick < 10)
            it.operation = OP_INT;
        else if (pick < 14)
            it.operation = OP_STR;
        else if (pick < 19)
            it.operation = OP_BSTR;
        else
            it.operation = OP_UNUSED;
        it.branch_id = ($urandom_range(9) < 7) ? base + 16'($urandom_range(7))
                                               : 16'($urandom);
        it.predicate = 4'($urandom_range(PRED_UNKNOWN_Z));
        if (it.predicate > PRED_EQ_C && $urandom_range(3) != 0)
            it.predicate = 4'($urandom_range(PRED_LE_B));
        it.operand_size = 2'($urandom_range(SIZE_64));
        it.left_operand = {$urandom, $urandom};
        it.right_operand = {$urandom, $urandom};
        case ($urandom_range(5))
            0: it.right_operand = it.left_operand;
            1: it.right_operand = it.left_operand + 64'($urandom_range(2)) - 64'd1;
            2: it.right_operand[7:0] = it.left_operand[7:0];
            3: it.left_operand = $urandom_range(1) ? S64_MIN : S64_MAX;
            default: ;
        endcase
        it.compare_result = ($urandom_range(9) < 4) ? 32'sd0 : $signed($urandom);
        it.compare_length = 6'($urandom);
        return it;
    endfunction

    function automatic t_branch_item make_item(input logic [1:0] op, input logic [15:0] id,
                                               input logic [3:0] pred, input logic [1:0] size,
                                               input logic signed [63:0] a,
                                               input logic signed [63:0] b,
                                               input logic signed [31:0] cres,
                                               input logic [5:0] len);
        t_branch_item it;
        it.operation = op;
        it.branch_id = id;
        it.predicate = pred;
        it.operand_size = size;
        it.left_operand = a;
        it.right_operand = b;
        it.compare_result = cres;
        it.compare_length = len;
        return it;
    endfunction

    task automatic add_row(input t_branch_item it, input logic typed,
                           input logic [7:0] value, input logic updated);
        t_directed_row row;
        row.item = it;
        row.typed = typed;
        row.want.value = value;
        row.want.updated = updated;
        directed_rows.push_back(row);
    endtask

    // Present one item, hold it until accepted, then record what it must produce
    task automatic send_item(input t_branch_item it, input logic typed,
                             input t_entry_result want);
        t_entry_result predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= it.operation;
        i_branch_id      <= it.branch_id;
        i_predicate      <= it.predicate;
        i_operand_size   <= it.operand_size;
        i_left_operand   <= it.left_operand;
        i_right_operand  <= it.right_operand;
        i_compare_result <= it.compare_result;
        i_compare_length <= it.compare_length;
        do
            @(posedge i_clk);
        while (o_stall);
        predicted = record_branch(it);
        expected_entries.push_back(typed ? want : predicted);
    endtask

    // Receiver: random stall, compare each accepted result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_entry_result want;
        i_stall <= ($urandom_range(99) < rx_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_entries.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: value %0d updated %0b",
                             o_entry_value, o_entry_updated);
            end else begin
                want = expected_entries.pop_front();
                if (o_entry_value !== want.value || o_entry_updated !== want.updated) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: value exp %0d got %0d, updated exp %0b got %0b",
                                 want.value, o_entry_value, want.updated, o_entry_updated);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int            counted;
        int            idx;
        t_branch_item  it;
        t_entry_result none;

        none = '0;
        foreach (direction_map[k])
            direction_map[k] = 8'd0;

        // Directed rows: fresh entries, extremes, every predicate and mode
        add_row(make_item(OP_INT, 16'h0000, PRED_EQ_A, SIZE_64, 0, 0, 0, 0), 1, 8'd1, 1);
        add_row(make_item(OP_INT, 16'h0000, PRED_GT_A, SIZE_64, S64_MIN, S64_MAX, 0, 0),
                1, 8'd3, 1);
        add_row(make_item(OP_INT, 16'h0000, PRED_GT_B, SIZE_64, S64_MAX, S64_MIN, 0, 0),
                1, 8'd3, 0);
        add_row(make_item(OP_INT, 16'hFFFF, PRED_UNKNOWN_A, SIZE_64, 0, 0, 0, 0), 1, 8'd0, 0);
        add_row(make_item(OP_UNUSED, 16'hFFFF, PRED_EQ_A, SIZE_64, 0, 0, 0, 0), 1, 8'd0, 0);
        add_row(make_item(OP_STR, 16'hFFFF, PRED_UNKNOWN_Z, SIZE_8, 0, 0, 0, 6'd63),
                1, 8'd1, 1);
        add_row(make_item(OP_STR, 16'hFFFF, PRED_EQ_A, SIZE_8, 0, 0, 32'sh8000_0000, 0),
                1, 8'd3, 1);
        // bounded mode packs the length, after which whole-byte modes leave it alone
        add_row(make_item(OP_BSTR, 16'd100, PRED_EQ_A, SIZE_8, 0, 0, 0, 6'd63),
                1, 8'd253, 1);
        add_row(make_item(OP_INT, 16'd100, PRED_EQ_A, SIZE_8, 1, 2, 0, 0), 1, 8'd253, 0);
        add_row(make_item(OP_STR, 16'd100, PRED_EQ_A, SIZE_8, 0, 0, 0, 0), 1, 8'd253, 0);
        add_row(make_item(OP_BSTR, 16'd100, PRED_EQ_A, SIZE_8, 0, 0, 32'sd1, 6'd0),
                1, 8'd3, 1);
        add_row(make_item(OP_BSTR, 16'd100, PRED_EQ_A, SIZE_8, 0, 0, 32'sd0, 6'd5),
                1, 8'd3, 0);
        // sign extension per size, upper bits must not matter
        add_row(make_item(OP_INT, 16'd200, PRED_LT_A, SIZE_8, 64'h7777_0000_0000_0080,
                          64'h0000_0000_0000_007F, 0, 0), 1, 8'd1, 1);
        add_row(make_item(OP_INT, 16'd201, PRED_GE_A, SIZE_16, 64'h1234_5678_9ABC_8000,
                          64'hFFFF_FFFF_FFFF_7FFF, 0, 0), 1, 8'd2, 1);
        add_row(make_item(OP_INT, 16'd202, PRED_LE_A, SIZE_32, 64'h0000_0001_8000_0000,
                          64'hFFFF_FFFF_7FFF_FFFF, 0, 0), 1, 8'd1, 1);
        add_row(make_item(OP_INT, 16'd203, PRED_LT_B, SIZE_64, S64_MAX, S64_MIN, 0, 0),
                1, 8'd2, 1);
        add_row(make_item(OP_INT, 16'd203, PRED_LE_B, SIZE_64, S64_MIN, S64_MIN, 0, 0),
                1, 8'd3, 1);
        add_row(make_item(OP_INT, 16'd204, PRED_EQ_B, SIZE_8, 64'h100, 64'h200, 0, 0),
                1, 8'd1, 1);
        add_row(make_item(OP_INT, 16'd204, PRED_EQ_C, SIZE_8, 1, 2, 0, 0), 1, 8'd3, 1);
        add_row(make_item(OP_INT, 16'd0, PRED_UNKNOWN_Z, SIZE_64, 0, 0, 0, 0), 1, 8'd3, 0);
        add_row(make_item(OP_BSTR, 16'd0, PRED_EQ_A, SIZE_8, 0, 0, 0, 6'd9), 1, 8'd3, 0);
        add_row(make_item(OP_BSTR, 16'd300, PRED_EQ_A, SIZE_8, 0, 0, -32'sd1, 6'd21),
                1, 8'd86, 1);
        add_row(make_item(OP_STR, 16'd300, PRED_EQ_A, SIZE_8, 0, 0, 0, 0), 1, 8'd86, 0);
        // mixed rows left to the predictor
        add_row(make_item(OP_INT, 16'd205, PRED_GE_B, SIZE_32, 64'hFFFF_FFFF_0000_0000,
                          64'h0000_0000_FFFF_FFFF, 0, 0), 0, 8'd0, 0);
        add_row(make_item(OP_INT, 16'd205, PRED_GT_B, SIZE_16, 64'h8001, 64'h7FFF, 0, 0),
                0, 8'd0, 0);

        // Reset, then the block clears its map with stall raised
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

        // Random items in three idling phases
        counted = 0;
        idx = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 20;
                rx_stall_pct = 69;
            end else if (counted < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 69;
                rx_stall_pct = 20;
            end else begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            // move the hot window now and then, edges of the map included
            if (idx % 40 == 0) begin
                case ($urandom_range(3))
                    0:       hot_base = 16'h0000;
                    1:       hot_base = 16'hFFF8;
                    default: hot_base = 16'($urandom) & 16'hFFF8;
                endcase
            end
            it = make_random_item(hot_base);
            send_item(it, 1'b0, none);
            idx++;
            counted++;
        end
        i_valid <= 1'b0;

        // Drain, then allow for anything still in flight
        while (expected_entries.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_entries.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
